// File: rtl/rrpc_pkg.sv
// Shared types and constants for the rounded-rectangle pixel coverage block.
// Holds the beat payload structs, the configuration struct and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrpc_pkg;

    // Surfaces wider or taller than this are clipped to it.
    localparam logic [12:0] MAX_SURFACE_DIM = 13'd4096;

    localparam int unsigned REG_COUNT    = 8;
    localparam int unsigned REG_IDX_BITS = $clog2(REG_COUNT);

    localparam logic [REG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X       = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Y       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_RECT_WIDTH     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_RECT_HEIGHT    = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_CORNER_RADIUS  = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_FILL_COLOUR    = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [11:0] local_col;
        logic [11:0] local_row;
    } t_rrpc_in;

    typedef struct packed {
        logic        write_enable;
        logic [23:0] pixel_address;
        logic [23:0] pixel_colour;
    } t_rrpc_out;

    typedef struct packed {
        logic        [12:0] surface_width;
        logic        [12:0] surface_height;
        logic signed [12:0] origin_x;
        logic signed [12:0] origin_y;
        logic        [12:0] rect_width;
        logic        [12:0] rect_height;
        logic        [11:0] corner_radius;
        logic        [23:0] fill_colour;
    } t_rrpc_cfg;

endpackage

`default_nettype wire

// File: rtl/rounded_rect_pixel_coverage.sv
// Top level of the rounded-rectangle pixel coverage block: register file,
// input register, result register. Depends on rrpc_pkg and rrpc_cover.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Signals                                   Beat
//  in        sink       i_in_valid, i_in_data, o_in_stall         one pixel position
//  out       source     o_out_valid, o_out_data, i_out_stall      write flag, address, colour
//  config    APB slave  psel, penable, pwrite, paddr, pwdata,     one 32-bit register
//                       prdata, pready
//
// One pixel is accepted every cycle while o_in_stall is low; it is captured in the input
// register, and its result is then loaded into the result register and presented.
// The coverage test and address multiply sit between the input and result registers.
// Reset (synchronous, active low) empties both stages and clears all config registers to zero.
// A stall on the result side holds the result register; the input register still fills
// if it is empty, and stall reaches the input side only when both stages are full.

module rounded_rect_pixel_coverage (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    input  rrpc_pkg::t_rrpc_in  i_in_data,
    output logic                o_in_stall,

    output logic                o_out_valid,
    output rrpc_pkg::t_rrpc_out o_out_data,
    input  logic                i_out_stall,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rrpc_pkg::*;

    t_rrpc_cfg             r_cfg;
    logic                  r_in_valid;
    t_rrpc_in              r_in_data;
    logic                  r_out_valid;
    t_rrpc_out             r_out_data;
    t_rrpc_out             n_out_data;
    logic                  out_load;
    logic                  in_load;
    logic                  cfg_write;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SURFACE_WIDTH:  r_cfg.surface_width  <= pwdata[12:0];
                REG_SURFACE_HEIGHT: r_cfg.surface_height <= pwdata[12:0];
                REG_ORIGIN_X:       r_cfg.origin_x       <= pwdata[12:0];
                REG_ORIGIN_Y:       r_cfg.origin_y       <= pwdata[12:0];
                REG_RECT_WIDTH:     r_cfg.rect_width     <= pwdata[12:0];
                REG_RECT_HEIGHT:    r_cfg.rect_height    <= pwdata[12:0];
                REG_CORNER_RADIUS:  r_cfg.corner_radius  <= pwdata[11:0];
                REG_FILL_COLOUR:    r_cfg.fill_colour    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SURFACE_WIDTH:  prdata = {19'b0, r_cfg.surface_width};
            REG_SURFACE_HEIGHT: prdata = {19'b0, r_cfg.surface_height};
            REG_ORIGIN_X:       prdata = {19'b0, r_cfg.origin_x};
            REG_ORIGIN_Y:       prdata = {19'b0, r_cfg.origin_y};
            REG_RECT_WIDTH:     prdata = {19'b0, r_cfg.rect_width};
            REG_RECT_HEIGHT:    prdata = {19'b0, r_cfg.rect_height};
            REG_CORNER_RADIUS:  prdata = {20'b0, r_cfg.corner_radius};
            REG_FILL_COLOUR:    prdata = {8'b0, r_cfg.fill_colour};
            default:            prdata = '0;
        endcase
    end

    rrpc_cover u_cover (
        .i_cfg    (r_cfg),
        .i_item   (r_in_data),
        .o_result (n_out_data)
    );

    // The result register takes a new beat when it is empty or being drained.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = r_in_valid && !out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (out_load && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/rrpc_cover.sv
// Coverage decision and framebuffer address for one pixel, purely combinational.
// Depends on rrpc_pkg for the payload and configuration structs.
`timescale 1ns / 1ps
`default_nettype none

module rrpc_cover (
    input  rrpc_pkg::t_rrpc_cfg i_cfg,
    input  rrpc_pkg::t_rrpc_in  i_item,
    output rrpc_pkg::t_rrpc_out o_result
);
    import rrpc_pkg::*;

    // Distance from the corner centre along one axis, zero between the bands.
    function automatic logic [12:0] axis_dist(input logic signed [13:0] t,
                                              input logic signed [13:0] n,
                                              input logic signed [13:0] r);
        logic signed [13:0] d;
        begin
            if (t < r) begin
                d = r - t;
            end else if (t >= n - r) begin
                d = t - (n - r - 14'sd1);
            end else begin
                d = '0;
            end
            axis_dist = d[12:0];
        end
    endfunction

    // A neighbour's distance differs from the pixel's own by at most one, so its
    // square follows from the pixel's square with an add or subtract.
    function automatic logic [24:0] nb_square(input logic [12:0] d,
                                              input logic [12:0] dn,
                                              input logic [24:0] sq);
        logic [24:0] twice;
        begin
            twice = {11'b0, d, 1'b0};
            if (dn == d + 13'd1) begin
                nb_square = sq + twice + 25'd1;
            end else if (dn + 13'd1 == d) begin
                nb_square = sq - twice + 25'd1;
            end else begin
                nb_square = sq;
            end
        end
    endfunction

    function automatic logic in_shape(input logic [24:0] a, input logic [24:0] b,
                                      input logic [24:0] rsq);
        begin
            in_shape = ({1'b0, a} + {1'b0, b}) <= {1'b0, rsq};
        end
    endfunction

    logic        [12:0] sw_lim;
    logic        [12:0] sh_lim;
    logic        [12:0] rad_lim;
    logic        [12:0] half_w;
    logic        [12:0] half_h;
    logic signed [13:0] col_s;
    logic signed [13:0] row_s;
    logic signed [13:0] w_s;
    logic signed [13:0] h_s;
    logic signed [13:0] rad_s;
    logic signed [13:0] px;
    logic signed [13:0] py;
    logic        [12:0] dx, dx_m, dx_p, dy, dy_m, dy_p;
    logic        [24:0] dx_ext, dy_ext, rad_ext;
    logic        [24:0] dx_sq, dy_sq, rad_sq;
    logic        [24:0] sq_xm, sq_xp, sq_ym, sq_yp;
    logic               in_rect, on_surface, on_edge;
    logic               in_c, in_l, in_r, in_u, in_d;
    logic               covered;
    logic        [24:0] row_base;
    logic        [24:0] py_ext;
    logic        [24:0] sw_ext;
    logic        [23:0] addr;

    always_comb begin
        sw_lim = (i_cfg.surface_width > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM
                                                         : i_cfg.surface_width;
        sh_lim = (i_cfg.surface_height > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM
                                                          : i_cfg.surface_height;

        half_w  = {1'b0, i_cfg.rect_width[12:1]};
        half_h  = {1'b0, i_cfg.rect_height[12:1]};
        rad_lim = {1'b0, i_cfg.corner_radius};
        if (rad_lim > half_w) begin
            rad_lim = half_w;
        end
        if (rad_lim > half_h) begin
            rad_lim = half_h;
        end

        col_s = {2'b00, i_item.local_col};
        row_s = {2'b00, i_item.local_row};
        w_s   = {1'b0, i_cfg.rect_width};
        h_s   = {1'b0, i_cfg.rect_height};
        rad_s = {1'b0, rad_lim};

        in_rect = (col_s < w_s) && (row_s < h_s);

        px = {i_cfg.origin_x[12], i_cfg.origin_x} + col_s;
        py = {i_cfg.origin_y[12], i_cfg.origin_y} + row_s;
        on_surface = !px[13] && !py[13] &&
                     (px < $signed({1'b0, sw_lim})) && (py < $signed({1'b0, sh_lim}));

        dx   = axis_dist(col_s, w_s, rad_s);
        dx_m = axis_dist(col_s - 14'sd1, w_s, rad_s);
        dx_p = axis_dist(col_s + 14'sd1, w_s, rad_s);
        dy   = axis_dist(row_s, h_s, rad_s);
        dy_m = axis_dist(row_s - 14'sd1, h_s, rad_s);
        dy_p = axis_dist(row_s + 14'sd1, h_s, rad_s);

        dx_ext  = {12'b0, dx};
        dy_ext  = {12'b0, dy};
        rad_ext = {12'b0, rad_lim};
        dx_sq   = dx_ext * dx_ext;
        dy_sq   = dy_ext * dy_ext;
        rad_sq  = rad_ext * rad_ext;

        sq_xm = nb_square(dx, dx_m, dx_sq);
        sq_xp = nb_square(dx, dx_p, dx_sq);
        sq_ym = nb_square(dy, dy_m, dy_sq);
        sq_yp = nb_square(dy, dy_p, dy_sq);

        in_c = in_shape(dx_sq, dy_sq, rad_sq);
        in_l = in_shape(sq_xm, dy_sq, rad_sq);
        in_r = in_shape(sq_xp, dy_sq, rad_sq);
        in_u = in_shape(dx_sq, sq_ym, rad_sq);
        in_d = in_shape(dx_sq, sq_yp, rad_sq);

        on_edge = (col_s == 14'sd0) || (row_s == 14'sd0) ||
                  (col_s + 14'sd1 == w_s) || (row_s + 14'sd1 == h_s);

        covered = in_rect && on_surface && in_c &&
                  (!i_item.kind || on_edge || !in_l || !in_r || !in_u || !in_d);

        // On the surface the position fits in 12 bits per axis.
        py_ext   = {13'b0, py[11:0]};
        sw_ext   = {12'b0, sw_lim};
        row_base = py_ext * sw_ext;
        addr     = row_base[23:0] + {12'b0, px[11:0]};

        o_result.write_enable  = covered;
        o_result.pixel_address = covered ? addr : '0;
        o_result.pixel_colour  = covered ? i_cfg.fill_colour : '0;
    end

endmodule

`default_nettype wire
